@@ rtl/psr_pkg.sv @@
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and codes for the polyphase resampler.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int MAX_PHASES = 64;
    localparam int MAX_TAPS = 512;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_PAD = 2'd2;

    localparam logic [1:0] REG_ORIG_STEP = 2'd0;
    localparam logic [1:0] REG_NEW_PHASES = 2'd1;
    localparam logic [1:0] REG_HALF_WIDTH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/psr_mac.sv @@
// ----------------------------------------------------------------------------
// psr_mac
// Serial multiply-accumulate with rounding and saturation of the Q.15 sum.
// ----------------------------------------------------------------------------
module psr_mac #(
    parameter int ACC_BITS = 48
) (
    input  logic               clk,
    input  logic               clear,
    input  logic               mul_en,
    input  logic               acc_en,
    input  logic signed [15:0] coef,
    input  logic signed [15:0] samp,
    output logic signed [15:0] value,
    output logic               clipped
);
    logic signed [31:0]       prod_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS:0]   rnd;
    logic signed [ACC_BITS-15:0] q;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= coef * samp;
        end
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (acc_en)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
    end

    always_comb
    begin
        // one guard bit so the rounding add cannot wrap
        rnd = {acc_reg[ACC_BITS-1], acc_reg} + (ACC_BITS+1)'(1 << 14);
        q = rnd[ACC_BITS:15];
        if (q > $signed((ACC_BITS-14)'(32767)))
        begin
            value = 16'sh7FFF;
            clipped = 1'b1;
        end
        else if (q < -$signed((ACC_BITS-14)'(32768)))
        begin
            value = 16'sh8000;
            clipped = 1'b1;
        end
        else
        begin
            value = q[15:0];
            clipped = 1'b0;
        end
    end
endmodule

@@ rtl/polyphase_sinc_resampler_top.sv @@
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler_top
// Rational-ratio polyphase FIR resampler for mono 16-bit audio.
// ----------------------------------------------------------------------------
// A load item writes the coefficient memory; the block stays idle. A sample
// or pad item that completes a row runs one serial MAC per output phase over
// T = 2*half_width + orig_step taps (at most MAX_TAPS), one tap per cycle from
// the coefficient and delay-line memories, then drains, rounds and emits each
// result once the last one is taken; a pass-through sample is emitted from the
// check state. Items are accepted only when idle with no result pending. The
// delay line is a circular buffer with a base pointer; after reset it is
// cleared by a pass over every entry during which no item is accepted.
module polyphase_sinc_resampler_top #(
    parameter int ACC_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // phase_index, tap_index, tap_value, sample
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value, phase, clipped
    output logic        m_tlast    // last
);
    import psr_pkg::*;

    localparam int TW = $clog2(MAX_TAPS);
    localparam int PW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

    state_t state_reg, state_next;

    logic [8:0] os_reg;
    logic [6:0] np_reg;
    logic [7:0] hw_reg;
    logic [31:0] real_reg, stream_reg, row_reg;
    logic [1:0]  func_reg;
    logic [15:0] samp_reg;
    logic [TW-1:0] base_reg;
    logic [TW:0]   clr_reg;
    logic [PW-1:0] ph_reg;
    logic [TW:0]   p_reg;
    logic [63:0] m_reg;
    logic [63:0] lim_reg;
    logic [15:0] oval_reg;
    logic [5:0]  oph_reg;
    logic        oclip_reg, olast_reg, ovalid_reg;
    logic        mul_v_reg, acc_v_reg, fire_reg;

    logic [15:0] coef_mem [MAX_PHASES*MAX_TAPS];
    logic [15:0] dl_mem [MAX_TAPS];
    logic [15:0] coef_rd_reg, dl_rd_reg;

    logic [8:0]  os_e;
    logic [6:0]  np_e;
    logic [TW-1:0] hw_e;
    logic [TW:0] taps_e;
    logic [TW:0] t2;

    always_comb
    begin
        os_e = (os_reg == '0) ? 9'd1 : os_reg;
        np_e = (np_reg == '0) ? 7'd1 : ((np_reg > 7'(MAX_PHASES)) ? 7'(MAX_PHASES) : np_reg);
        hw_e = (32'(hw_reg) > 32'(MAX_TAPS - 1)) ? TW'(MAX_TAPS - 1) : TW'(hw_reg);
        t2 = (TW+1)'(2 * 32'(hw_e) + 32'(os_e) > 32'(MAX_TAPS) ? MAX_TAPS
                     : 2 * 32'(hw_e) + 32'(os_e));
        taps_e = t2;
    end

    logic in_acc, cfg_acc, out_acc;
    logic [1:0] func;
    logic [5:0] in_ph;
    logic [8:0] in_tap;
    assign func = s_tuser;
    assign in_ph = s_tdata[5:0];
    assign in_tap = s_tdata[14:6];
    assign s_tready = (state_reg == ST_IDLE) && clr_reg[TW] && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign in_acc = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign out_acc = ovalid_reg && m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {1'b0, oclip_reg, oph_reg, oval_reg};
    assign m_tlast = olast_reg;

    // coefficient memory
    logic [TW-1:0] rd_tap;
    assign rd_tap = p_reg[TW-1:0];
    always_ff @(posedge clk)
    begin
        if (in_acc && func == FUNC_LOAD && 32'(in_ph) < 32'(MAX_PHASES)
            && 32'(in_tap) < 32'(MAX_TAPS))
        begin
            coef_mem[{PW'(in_ph), TW'(in_tap)}] <= s_tdata[30:15];
        end
        coef_rd_reg <= coef_mem[{ph_reg, rd_tap}];
    end

    // delay line: entry base+k holds the k-th newest value
    logic [TW-1:0] dl_wa, dl_ra;
    logic dl_we;
    logic [15:0] dl_wd;
    assign dl_ra = base_reg + TW'(taps_e - (TW+1)'(1) - p_reg);
    always_comb
    begin
        dl_we = 1'b0;
        dl_wa = base_reg - TW'(1);
        dl_wd = (func == FUNC_SAMPLE) ? s_tdata[46:31] : 16'd0;
        if (!clr_reg[TW])
        begin
            dl_we = 1'b1;
            dl_wa = clr_reg[TW-1:0];
            dl_wd = '0;
        end
        else if (in_acc && (func == FUNC_SAMPLE || func == FUNC_PAD))
        begin
            dl_we = 1'b1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[dl_wa] <= dl_wd;
        end
        dl_rd_reg <= dl_mem[dl_ra];
    end

    logic signed [15:0] mac_val;
    logic mac_clip;
    logic mac_clear, mul_en;
    psr_mac #(.ACC_BITS(ACC_BITS)) u_mac (
        .clk    (clk),
        .clear  (mac_clear),
        .mul_en (mul_v_reg),
        .acc_en (acc_v_reg),
        .coef   (coef_rd_reg),
        .samp   (dl_rd_reg),
        .value  (mac_val),
        .clipped(mac_clip)
    );

    logic [63:0] need;
    assign need = 64'(row_reg) * 64'(os_e) + 64'(taps_e - (TW+1)'(hw_e));

    always_comb
    begin
        state_next = state_reg;
        mac_clear = 1'b0;
        mul_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (func == FUNC_SAMPLE || func == FUNC_PAD))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                mac_clear = 1'b1;
                if (os_e == 9'(np_e) || 64'(stream_reg) < need)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (m_reg * 64'(os_e) >= lim_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (p_reg == taps_e - (TW+1)'(1))
                begin
                    state_next = ST_DRAIN;
                end
                mul_en = !(m_reg * 64'(os_e) >= lim_reg);
            end
            ST_DRAIN: state_next = ST_ROUND;
            ST_ROUND: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!ovalid_reg)
                begin
                    mac_clear = 1'b1;
                    state_next = (fire_reg) ? ST_IDLE : ST_MAC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            os_reg <= 9'd1;
            np_reg <= 7'd1;
            hw_reg <= 8'd7;
            real_reg <= '0;
            stream_reg <= '0;
            row_reg <= '0;
            base_reg <= '0;
            clr_reg <= '0;
            ovalid_reg <= 1'b0;
            mul_v_reg <= 1'b0;
            acc_v_reg <= 1'b0;
            fire_reg <= 1'b0;
            func_reg <= '0;
            samp_reg <= '0;
            ph_reg <= '0;
            p_reg <= '0;
            m_reg <= '0;
            lim_reg <= '0;
            oval_reg <= '0;
            oph_reg <= '0;
            oclip_reg <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mul_v_reg <= mul_en;
            acc_v_reg <= mul_v_reg;
            if (!clr_reg[TW])
            begin
                clr_reg <= clr_reg + (TW+1)'(1);
            end
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    REG_ORIG_STEP: os_reg <= cfg_data;
                    REG_NEW_PHASES: np_reg <= cfg_data[6:0];
                    REG_HALF_WIDTH: hw_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_acc)
            begin
                ovalid_reg <= 1'b0;
            end
            if (in_acc && (func == FUNC_SAMPLE || func == FUNC_PAD))
            begin
                base_reg <= base_reg - TW'(1);
                stream_reg <= stream_reg + 32'd1;
                func_reg <= func;
                samp_reg <= s_tdata[46:31];
                if (func == FUNC_SAMPLE)
                begin
                    real_reg <= real_reg + 32'd1;
                end
            end
            unique case (state_reg)
                ST_CHECK:
                begin
                    ph_reg <= '0;
                    p_reg <= '0;
                    fire_reg <= 1'b0;
                    m_reg <= 64'(row_reg) * 64'(np_e);
                    lim_reg <= 64'(np_e) * 64'(real_reg);
                    if (os_e == 9'(np_e) && func_reg == FUNC_SAMPLE)
                    begin
                        ovalid_reg <= 1'b1;
                        oval_reg <= samp_reg;
                        oph_reg <= '0;
                        oclip_reg <= 1'b0;
                        olast_reg <= 1'b1;
                    end
                end
                ST_MAC:
                begin
                    if (m_reg * 64'(os_e) >= lim_reg)
                    begin
                        row_reg <= row_reg + 32'd1;
                    end
                    else
                    begin
                        p_reg <= p_reg + (TW+1)'(1);
                    end
                end
                ST_ROUND:
                begin
                    // next phase exists only if in range and below np
                    fire_reg <= (32'(ph_reg) + 32'd1 >= 32'(np_e))
                        || ((m_reg + 64'd1) * 64'(os_e) >= lim_reg);
                end
                ST_EMIT:
                begin
                    if (!ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        oval_reg <= mac_val;
                        oph_reg <= 6'(ph_reg);
                        oclip_reg <= mac_clip;
                        olast_reg <= fire_reg;
                        p_reg <= '0;
                        ph_reg <= ph_reg + PW'(1);
                        m_reg <= m_reg + 64'd1;
                        if (fire_reg)
                        begin
                            row_reg <= row_reg + 32'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) in_acc |-> (state_reg == ST_IDLE);
    endproperty
    assert property (p_no_accept_busy) else $error("item accepted while busy");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n) (m_tvalid && !m_tready) |=> m_tvalid;
    endproperty
    assert property (p_out_hold) else $error("output item dropped");

    property p_clear_blocks;
        @(posedge clk) disable iff (!rst_n) !clr_reg[TW] |-> !s_tready;
    endproperty
    assert property (p_clear_blocks) else $error("item accepted during clear");
endmodule

@@ tb/polyphase_sinc_resampler_top_tb.sv @@
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler_top_tb
// Self-checking bench for the rational polyphase resampler: items go in over
// the slave stream, results are predicted from a local copy of the delay line,
// coefficient memory and counters and compared against the master stream.
// ----------------------------------------------------------------------------
module polyphase_sinc_resampler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psr_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [15:0] value;
        logic [5:0]  phase;
        logic        clipped;
        logic        last;
    } pcm_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // local copy of the block state
    logic [15:0] line_mem [MAX_TAPS];
    logic [15:0] coef_mem [MAX_PHASES][MAX_TAPS];
    bit          coef_set [MAX_PHASES][MAX_TAPS];
    int unsigned real_cnt;
    int unsigned stream_cnt;
    int unsigned row_cnt;
    int unsigned step_reg;
    int unsigned phases_reg;
    int unsigned half_reg;

    pcm_out_t    pending_pcm [$];
    int          errors;
    int          quiet_cycles;
    bit          tx_gaps;
    bit          rx_gaps;
    int          rx_hold;
    int          rx_burst;

    polyphase_sinc_resampler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned eff_step();
        return (step_reg == 0) ? 1 : step_reg;
    endfunction

    function automatic int unsigned eff_phases();
        int unsigned np;
        np = (phases_reg == 0) ? 1 : phases_reg;
        return (np > MAX_PHASES) ? MAX_PHASES : np;
    endfunction

    function automatic int unsigned eff_taps();
        int unsigned t;
        t = 2 * half_reg + eff_step();
        return (t > MAX_TAPS) ? MAX_TAPS : t;
    endfunction

    function automatic int busy_cycles();
        return eff_phases() * (eff_taps() + 4) + 16;
    endfunction

    // rounded, saturated result of one phase over the current window
    function automatic pcm_out_t mac_phase(int unsigned ph, int unsigned taps);
        pcm_out_t    o;
        longint      acc;
        logic [47:0] wrapped;
        longint      q;
        acc = 0;
        for (int p = 0; p < taps; p++)
            acc += longint'($signed(coef_mem[ph][p])) *
                   longint'($signed(line_mem[taps - 1 - p]));
        wrapped = acc[47:0];
        q = ($signed({{16{wrapped[47]}}, wrapped}) + 64'sd16384) >>> 15;
        o.phase = ph[5:0];
        o.last = 1'b0;
        if (q >= -32768 && q <= 32767)
        begin
            o.value = q[15:0];
            o.clipped = 1'b0;
        end
        else
        begin
            o.value = (q < 0) ? 16'h8000 : 16'h7fff;
            o.clipped = 1'b1;
        end
        return o;
    endfunction

    task automatic predict_item(input logic [1:0] f, input logic [5:0] ph,
                                input logic [8:0] tp, input logic [15:0] tv,
                                input logic [15:0] smp);
        int unsigned     os;
        int unsigned     np;
        int unsigned     taps;
        longint unsigned need;
        longint unsigned pos;
        pcm_out_t        o;
        pcm_out_t        row_out [$];
        if (f == FUNC_LOAD)
        begin
            coef_mem[ph][tp] = tv;
            coef_set[ph][tp] = 1'b1;
            return;
        end
        if (f == FUNC_NONE)
            return;
        os = eff_step();
        np = eff_phases();
        taps = eff_taps();
        for (int i = MAX_TAPS - 1; i > 0; i--)
            line_mem[i] = line_mem[i - 1];
        line_mem[0] = (f == FUNC_SAMPLE) ? smp : 16'h0;
        stream_cnt++;
        if (f == FUNC_SAMPLE)
            real_cnt++;
        if (os == np)
        begin
            if (f == FUNC_SAMPLE)
            begin
                o.value = smp;
                o.phase = '0;
                o.clipped = 1'b0;
                o.last = 1'b1;
                pending_pcm.push_back(o);
            end
            return;
        end
        need = longint'(row_cnt) * os + (taps - half_reg);
        if (longint'(stream_cnt) < need)
            return;
        for (int unsigned j = 0; j < np; j++)
        begin
            pos = longint'(row_cnt) * np + j;
            if (pos * os >= longint'(np) * real_cnt)
                break;
            row_out.push_back(mac_phase(j, taps));
        end
        if (row_out.size() > 0)
            row_out[row_out.size() - 1].last = 1'b1;
        foreach (row_out[k])
            pending_pcm.push_back(row_out[k]);
        row_cnt++;
    endtask

    task automatic send_item(input logic [1:0] f, input logic [5:0] ph,
                             input logic [8:0] tp, input logic [15:0] tv,
                             input logic [15:0] smp);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= f;
        s_tdata <= {1'b0, smp, tv, tp, ph};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(f, ph, tp, tv, smp);
        if (tx_gaps && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4))
                @(negedge clk);
        end
    endtask

    task automatic tx_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_sample(input logic [15:0] smp);
        send_item(FUNC_SAMPLE, 6'($urandom), 9'($urandom), 16'($urandom), smp);
    endtask

    task automatic send_pad();
        send_item(FUNC_PAD, 6'($urandom), 9'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] rand_pcm();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ORIG_STEP: step_reg = val;
            REG_NEW_PHASES: phases_reg = val[6:0];
            REG_HALF_WIDTH: half_reg = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait out every result, then the longest silent row
    task automatic drain();
        tx_quiet();
        while (pending_pcm.size() != 0)
            @(posedge clk);
        repeat (busy_cycles())
            @(posedge clk);
    endtask

    task automatic set_ratio(input int unsigned os, input int unsigned np,
                             input int unsigned hw);
        write_reg(REG_ORIG_STEP, os[8:0]);
        write_reg(REG_NEW_PHASES, np[8:0]);
        write_reg(REG_HALF_WIDTH, hw[8:0]);
    endtask

    // every coefficient the current setting reads must be written first
    task automatic load_kernel(input bit big);
        logic [15:0] c;
        if (eff_step() == eff_phases())
            return;
        for (int j = 0; j < eff_phases(); j++)
            for (int p = 0; p < eff_taps(); p++)
                if (!coef_set[j][p])
                begin
                    c = (big || $urandom_range(0, 3) == 0) ? 16'($urandom)
                        : 16'($signed($urandom_range(0, 4095)) - 2048);
                    send_item(FUNC_LOAD, j[5:0], p[8:0], c, 16'($urandom));
                end
    endtask

    task automatic stream_tail();
        repeat (half_reg + eff_step())
            send_pad();
    endtask

    task automatic test_passthrough();
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_pad();
        send_item(FUNC_NONE, 6'h3f, 9'h1ff, 16'hffff, 16'hffff);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        drain();
        // new_phases above the maximum saturates to match orig_step
        set_ratio(64, 100, 3);
        repeat (6)
            send_sample(rand_pcm());
        drain();
    endtask

    task automatic test_edge_taps();
        // writes at the top of the address range, never read back
        send_item(FUNC_LOAD, 6'h3f, 9'h1ff, 16'h8000, 16'h0000);
        send_item(FUNC_LOAD, 6'h2a, 9'h155, 16'h7fff, 16'hffff);
        send_item(FUNC_NONE, 6'h15, 9'h0aa, 16'h1234, 16'h4321);
        drain();
    endtask

    task automatic test_clipping();
        set_ratio(2, 3, 1);
        for (int j = 0; j < 3; j++)
            for (int p = 0; p < 4; p++)
                send_item(FUNC_LOAD, j[5:0], p[8:0], (j == 0) ? 16'h8000 : 16'h7fff,
                          16'h0000);
        repeat (3)
            send_sample(16'h8000);
        repeat (3)
            send_sample(16'h7fff);
        send_sample(16'h0001);
        send_item(FUNC_NONE, 6'h00, 9'h000, 16'h0000, 16'h0000);
        stream_tail();
        drain();
    endtask

    task automatic test_zero_regs();
        set_ratio(0, 0, 0);
        send_sample(rand_pcm());
        send_sample(rand_pcm());
        drain();
        write_reg(REG_NEW_PHASES, 9'd2);
        load_kernel(1'b0);
        repeat (5)
            send_sample(rand_pcm());
        stream_tail();
        drain();
    endtask

    task automatic test_full_row();
        // every phase fires from a single tap, so each sample gives a full row
        set_ratio(1, 64, 0);
        load_kernel(1'b0);
        repeat (4)
            send_sample(rand_pcm());
        stream_tail();
        drain();
    endtask

    task automatic test_backpressure();
        set_ratio(1, 2, 2);
        load_kernel(1'b0);
        rx_hold = 1500;
        repeat (60)
            send_sample(rand_pcm());
        stream_tail();
        drain();
    endtask

    task automatic test_random_streams();
        int sent;
        int seg;
        sent = 0;
        seg = 0;
        while (sent < 200)
        begin
            if (sent > 150)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            set_ratio($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 4));
            load_kernel(seg % 3 == 0);
            repeat ($urandom_range(15, 40))
            begin
                case ($urandom_range(0, 19))
                    0: send_item(FUNC_NONE, 6'($urandom), 9'($urandom), 16'($urandom),
                                 16'($urandom));
                    1: send_item(FUNC_LOAD, 6'($urandom), 9'($urandom), 16'($urandom),
                                 16'($urandom));
                    2: send_pad();
                    default: send_sample(rand_pcm());
                endcase
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                stream_tail();
            drain();
            seg++;
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else if (rx_burst > 0)
        begin
            m_tready <= 1'b0;
            rx_burst--;
        end
        else if (rx_gaps && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_burst = $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pcm_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pcm.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%h phase=%0d clipped=%b last=%b",
                         $realtime, m_tdata[15:0], m_tdata[21:16], m_tdata[22], m_tlast);
            end
            else
            begin
                want = pending_pcm.pop_front();
                if (m_tdata[15:0] !== want.value)
                begin
                    errors++;
                    $display("%0t: value expected %h actual %h", $realtime, want.value,
                             m_tdata[15:0]);
                end
                if (m_tdata[21:16] !== want.phase)
                begin
                    errors++;
                    $display("%0t: phase expected %0d actual %0d", $realtime, want.phase,
                             m_tdata[21:16]);
                end
                if (m_tdata[22] !== want.clipped)
                begin
                    errors++;
                    $display("%0t: clipped expected %b actual %b", $realtime, want.clipped,
                             m_tdata[22]);
                end
                if (m_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $realtime, want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        rx_hold = 0;
        rx_burst = 0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        foreach (line_mem[i])
            line_mem[i] = '0;
        foreach (coef_set[j, p])
        begin
            coef_set[j][p] = 1'b0;
            coef_mem[j][p] = '0;
        end
        real_cnt = 0;
        stream_cnt = 0;
        row_cnt = 0;
        step_reg = 1;
        phases_reg = 1;
        half_reg = 7;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_edge_taps();
        test_clipping();
        test_zero_regs();
        test_full_row();
        test_backpressure();
        test_random_streams();

        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/psr_pkg.sv
rtl/psr_mac.sv
rtl/polyphase_sinc_resampler_top.sv
tb/polyphase_sinc_resampler_top_tb.sv
